// ===== src/text_console_writer_defines.svh =====
// assertion macros for the text console writer
// used by modules that check their own control logic; expects clk and rst_n in scope
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("text console writer: check failed");
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer: sequence check failed");
`else
`define TCW_ASSERT(lbl, prop)
`define TCW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/tcw_pkg.sv =====
// shared types and constants for the text console writer
// no dependencies
package tcw_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 12;
  localparam int CELL_W = 16;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam logic REG_ATTR_IDX = 1'b0;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] wpos;
    logic             store;
    logic             scroll;
  } cur_upd_t;

endpackage

// ===== src/tcw_cell_mem.sv =====
// cell store: one write port, one read port with registered read data
// depends on tcw_pkg for the cell width
module tcw_cell_mem #(
  parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [tcw_pkg::CELL_W-1:0]  wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [tcw_pkg::CELL_W-1:0]  rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tcw_cursor.sv =====
// cursor update for one put item: control codes, wrap and scroll detect
// depends on tcw_pkg for the update struct and character codes
module tcw_cursor #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic [tcw_pkg::COL_W-1:0] col_i,
  input  logic [tcw_pkg::ROW_W-1:0] row_i,
  input  logic [7:0]                char_code,
  output tcw_pkg::cur_upd_t         upd
);

  localparam int CW = tcw_pkg::COL_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int PW = tcw_pkg::POS_W;
  localparam int TAB_N = 2 ** CW;

  logic [CW:0]   tab_stop [TAB_N];
  logic [CW:0]   col_inc;
  logic [CW:0]   col_fin;
  logic [RW-1:0] row_adv;
  logic [RW-1:0] row_fin;
  logic          scroll;

  // next tab stop for every column, worked out at elaboration
  genvar g;
  generate
    for (g = 0; g < TAB_N; g++) begin : g_tab
      assign tab_stop[g] = (CW + 1)'((g / TAB_WIDTH + 1) * TAB_WIDTH);
    end
  endgenerate

  always_comb begin
    col_inc   = {1'b0, col_i} + (CW + 1)'(1);
    col_fin   = {1'b0, col_i};
    row_adv   = row_i;
    upd.store = 1'b0;
    case (char_code)
      tcw_pkg::CHAR_LF: begin
        col_fin = '0;
        row_adv = row_i + RW'(1);
      end
      tcw_pkg::CHAR_CR: begin
        col_fin = '0;
      end
      tcw_pkg::CHAR_TAB: begin
        if (tab_stop[col_i] >= (CW + 1)'(COLUMNS)) begin
          col_fin = '0;
          row_adv = row_i + RW'(1);
        end else begin
          col_fin = tab_stop[col_i];
        end
      end
      default: begin
        upd.store = 1'b1;
        if (col_inc >= (CW + 1)'(COLUMNS)) begin
          col_fin = '0;
          row_adv = row_i + RW'(1);
        end else begin
          col_fin = col_inc;
        end
      end
    endcase

    scroll     = (row_adv >= RW'(ROWS));
    row_fin    = scroll ? RW'(ROWS - 1) : row_adv;
    upd.col    = col_fin[CW-1:0];
    upd.row    = row_fin;
    upd.scroll = scroll;
    upd.pos    = PW'(row_fin) * PW'(COLUMNS) + PW'(col_fin[CW-1:0]);
    upd.wpos   = PW'(row_i) * PW'(COLUMNS) + PW'(col_i);
  end

endmodule

// ===== src/text_console_writer.sv =====
// channel | handshake                     | fields
// in      | in_valid, in_stall            | in_command, in_char_code, in_cell_index
// out     | out_valid, out_stall          | out_cursor_position, out_read_data, out_scrolled
// cfg     | psel, penable, pwrite, pready | paddr, pwdata, prdata (text_attribute at address 0)
// an ordinary character or a nop gives its result in the cycle after it is accepted;
// a read passes through ST_READ; clear runs ST_CLEAR, a put that scrolls runs ST_COPY then ST_BLANK
// clear and scroll are paced by the single write port of the cell store, one cell a cycle
// synchronous active-low reset clears cursor, attribute (to 7) and control; cells stay undefined
// in_stall is high while the control is out of idle or an unaccepted result blocks the output register
// depends on tcw_pkg, tcw_cursor, tcw_cell_mem and text_console_writer_defines.svh
`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_cursor_position,
  output logic [15:0] out_read_data,
  output logic        out_scrolled,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW       = tcw_pkg::COL_W;
  localparam int RW       = tcw_pkg::ROW_W;
  localparam int PW       = tcw_pkg::POS_W;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int COPY_END = CELLS - COLUMNS;

  tcw_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [7:0]        attr_r;
  logic [PW-1:0]     pend_pos_r, pend_pos_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [10:0]       out_pos_r, out_pos_nxt;
  logic [15:0]       out_rdata_r, out_rdata_nxt;
  logic              out_scrolled_r, out_scrolled_nxt;

  logic              accept;
  logic              cfg_wr;
  logic [15:0]       blank;
  tcw_pkg::cur_upd_t upd;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [15:0]       mem_rdata;

  tcw_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_cursor (
    .col_i     (col_r),
    .row_i     (row_r),
    .char_code (in_char_code),
    .upd       (upd)
  );

  tcw_cell_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (AW)
  ) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall = (state_r != tcw_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign blank    = {attr_r, tcw_pkg::CHAR_BLANK};

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_read_data       = out_rdata_r;
  assign out_scrolled        = out_scrolled_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == tcw_pkg::REG_ATTR_IDX) ? {24'd0, attr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_wr && (paddr[2] == tcw_pkg::REG_ATTR_IDX)) begin
      attr_r <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_IDLE;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_pos_r     <= pend_pos_nxt;
    rd_ok_r        <= rd_ok_nxt;
    out_pos_r      <= out_pos_nxt;
    out_rdata_r    <= out_rdata_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    pend_pos_nxt     = pend_pos_r;
    rd_ok_nxt        = rd_ok_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_pos_nxt      = out_pos_r;
    out_rdata_nxt    = out_rdata_r;
    out_scrolled_nxt = out_scrolled_r;
    mem_we           = 1'b0;
    mem_waddr        = AW'(upd.wpos);
    mem_wdata        = {attr_r, in_char_code};
    mem_re           = 1'b0;
    mem_raddr        = AW'(in_cell_index);

    case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_command)
            tcw_pkg::CMD_PUT: begin
              col_nxt = upd.col;
              row_nxt = upd.row;
              mem_we  = upd.store;
              if (upd.scroll) begin
                state_nxt    = tcw_pkg::ST_COPY;
                cnt_nxt      = '0;
                pend_pos_nxt = upd.pos;
              end else begin
                out_valid_nxt    = 1'b1;
                out_pos_nxt      = upd.pos[10:0];
                out_rdata_nxt    = '0;
                out_scrolled_nxt = 1'b0;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              state_nxt    = tcw_pkg::ST_CLEAR;
              cnt_nxt      = '0;
              col_nxt      = '0;
              row_nxt      = '0;
              pend_pos_nxt = '0;
            end
            tcw_pkg::CMD_READ: begin
              mem_re       = 1'b1;
              rd_ok_nxt    = (PW'(in_cell_index) < PW'(CELLS));
              pend_pos_nxt = upd.wpos;
              state_nxt    = tcw_pkg::ST_READ;
            end
            default: begin
              // unused command: report cursor only
              out_valid_nxt    = 1'b1;
              out_pos_nxt      = upd.wpos[10:0];
              out_rdata_nxt    = '0;
              out_scrolled_nxt = 1'b0;
            end
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        out_valid_nxt    = 1'b1;
        out_pos_nxt      = pend_pos_r[10:0];
        out_rdata_nxt    = rd_ok_r ? mem_rdata : 16'd0;
        out_scrolled_nxt = 1'b0;
        state_nxt        = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_COPY: begin
        // read one row ahead, write the previous read one cell behind
        if (cnt_r < AW'(COPY_END)) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r + AW'(COLUMNS);
        end
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (cnt_r == AW'(COPY_END)) begin
          state_nxt = tcw_pkg::ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      tcw_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = blank;
        if (cnt_r == AW'(CELLS - 1)) begin
          state_nxt        = tcw_pkg::ST_IDLE;
          out_valid_nxt    = 1'b1;
          out_pos_nxt      = pend_pos_r[10:0];
          out_rdata_nxt    = '0;
          out_scrolled_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = blank;
        if (cnt_r == AW'(CELLS - 1)) begin
          state_nxt        = tcw_pkg::ST_IDLE;
          out_valid_nxt    = 1'b1;
          out_pos_nxt      = pend_pos_r[10:0];
          out_rdata_nxt    = '0;
          out_scrolled_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  `TCW_ASSERT(a_row_in_range, row_r < RW'(ROWS))
  `TCW_ASSERT(a_col_in_range, col_r < CW'(COLUMNS))
  `TCW_ASSERT(a_out_empty_while_busy, (state_r != tcw_pkg::ST_IDLE) |-> !out_valid_r)
  `TCW_ASSERT(a_scroll_leaves_last_row, (out_valid_r && out_scrolled_r) |-> (row_r == RW'(ROWS - 1)))
  `TCW_ASSERT_NEXT(a_copy_hands_to_blank, (state_r == tcw_pkg::ST_COPY) && (cnt_r == AW'(COPY_END)), (state_r == tcw_pkg::ST_BLANK) && (cnt_r == AW'(COPY_END)))

endmodule

// ===== tb/tb_text_console_writer.sv =====
// self-checking testbench for text_console_writer: directed and random command items
// against a cycle-free model of the screen, with random idling on both channels
// depends on tcw_pkg and the text_console_writer rtl
`timescale 1ns / 100ps

module tb_text_console_writer;

  localparam int COLUMNS   = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS      = tcw_pkg::ROWS_DEF;
  localparam int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int MAX_INDEX = 2047;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_ATTR  = 3'd0;
  localparam logic [2:0] ADDR_SPARE = 3'd4;

  localparam int STUCK_LIMIT = 20000;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] read_data;
    logic        scrolled;
  } console_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [7:0]  in_char_code;
  logic [10:0] in_cell_index;
  logic        out_valid;
  logic        out_stall;
  logic [10:0] out_cursor_position;
  logic [15:0] out_read_data;
  logic        out_scrolled;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // screen model
  logic [15:0] screen_model [0:CELLS-1];
  bit          cell_written [0:CELLS-1];
  int          cursor_col_model;
  int          cursor_row_model;
  logic [7:0]  attr_model;

  console_result_t pending_results[$];
  console_result_t popped_result;
  int error_count;
  int stuck_cycles;
  int send_idle_pct;
  int out_stall_pct;

  text_console_writer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_position (out_cursor_position),
    .out_read_data       (out_read_data),
    .out_scrolled        (out_scrolled),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // apply one command to the screen model and give the result it must produce
  task automatic update_screen(input logic [1:0] cmd, input logic [7:0] code,
                               input logic [10:0] idx, output console_result_t res);
    int pos;
    res = '0;
    case (cmd)
      tcw_pkg::CMD_PUT: begin
        if (code == tcw_pkg::CHAR_LF) begin
          cursor_col_model = 0;
          cursor_row_model++;
        end else if (code == tcw_pkg::CHAR_CR) begin
          cursor_col_model = 0;
        end else if (code == tcw_pkg::CHAR_TAB) begin
          cursor_col_model = (cursor_col_model / TAB_WIDTH + 1) * TAB_WIDTH;
          if (cursor_col_model >= COLUMNS) begin
            cursor_col_model = 0;
            cursor_row_model++;
          end
        end else begin
          pos = cursor_row_model * COLUMNS + cursor_col_model;
          screen_model[pos] = {attr_model, code};
          cell_written[pos] = 1'b1;
          cursor_col_model++;
          if (cursor_col_model >= COLUMNS) begin
            cursor_col_model = 0;
            cursor_row_model++;
          end
        end
        if (cursor_row_model >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
            cell_written[i] = cell_written[i + COLUMNS];
          end
          for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_model[i] = {attr_model, tcw_pkg::CHAR_BLANK};
            cell_written[i] = 1'b1;
          end
          cursor_row_model = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_model[i] = {attr_model, tcw_pkg::CHAR_BLANK};
          cell_written[i] = 1'b1;
        end
        cursor_col_model = 0;
        cursor_row_model = 0;
      end
      tcw_pkg::CMD_READ: begin
        if (idx < CELLS) res.read_data = screen_model[idx];
      end
      default: ;
    endcase
    res.cursor_position = 11'(cursor_row_model * COLUMNS + cursor_col_model);
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] code,
                           input logic [10:0] idx);
    console_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_char_code  <= code;
    in_cell_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_screen(cmd, code, idx, res);
    pending_results.push_back(res);
  endtask

  task automatic put_char(input logic [7:0] code);
    send_item(tcw_pkg::CMD_PUT, code, 11'($urandom));
  endtask

  task automatic read_cell(input int idx);
    send_item(tcw_pkg::CMD_READ, 8'($urandom), 11'(idx));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_ATTR) attr_model = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_attribute();
    logic [31:0] data;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ATTR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    if (data !== {24'h0, attr_model}) begin
      $display("%0t: text_attribute readback mismatch: expected %0h, actual %0h",
               $time, {24'h0, attr_model}, data);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // reads go to cells already written, near the cursor or anywhere, or past the screen
  function automatic logic [10:0] pick_read_index();
    int r;
    int idx;
    r = $urandom_range(99);
    if (r < 10) idx = $urandom_range(MAX_INDEX, CELLS);
    else if (r < 45) idx = cursor_row_model * COLUMNS + $urandom_range(COLUMNS - 1, 0);
    else idx = $urandom_range(CELLS - 1, 0);
    if (idx < CELLS && !cell_written[idx]) idx = $urandom_range(MAX_INDEX, CELLS);
    return 11'(idx);
  endfunction

  task automatic send_random_item();
    int r;
    r = $urandom_range(99);
    if (r < 55) put_char(8'($urandom));
    else if (r < 62) put_char(tcw_pkg::CHAR_LF);
    else if (r < 65) put_char(tcw_pkg::CHAR_CR);
    else if (r < 72) put_char(tcw_pkg::CHAR_TAB);
    else if (r < 93) send_item(tcw_pkg::CMD_READ, 8'($urandom), pick_read_index());
    else if (r < 96) send_item(CMD_UNUSED, 8'($urandom), 11'($urandom));
    else if (r < 97) send_item(tcw_pkg::CMD_CLEAR, 8'($urandom), 11'($urandom));
    // a run of 10 to 40 printable characters, which may wrap at the right edge
    else repeat ($urandom_range(40, 10)) put_char(8'($urandom_range(8'h7E, 8'h21)));
  endtask

  task automatic run_random_traffic(input logic [7:0] attr, input int count,
                                    input bit pause_midway);
    wait_results_drained();
    write_register(ADDR_ATTR, attr);
    check_attribute();
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) wait_results_drained();
      send_random_item();
    end
  endtask

  task automatic test_register_access();
    check_attribute();
    write_register(ADDR_ATTR, 8'h1F);
    write_register(ADDR_SPARE, 8'hA5);
    check_attribute();
  endtask

  task automatic test_put_and_controls();
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    read_cell(0);
    read_cell(2);
    put_char(tcw_pkg::CHAR_CR);
    put_char(tcw_pkg::CHAR_TAB);
    put_char(8'h7E);
    read_cell(TAB_WIDTH);
    put_char(tcw_pkg::CHAR_LF);
    send_item(CMD_UNUSED, 8'hFF, 11'h7FF);
    send_item(tcw_pkg::CMD_CLEAR, 8'h00, 11'h000);
    read_cell(0);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(MAX_INDEX);
    // tabs until the right edge sends the cursor to the next line
    repeat (COLUMNS / TAB_WIDTH) put_char(tcw_pkg::CHAR_TAB);
  endtask

  task automatic test_scroll();
    while (cursor_row_model < ROWS - 1) put_char(tcw_pkg::CHAR_LF);
    put_char(8'h5A);
    put_char(tcw_pkg::CHAR_LF);
    read_cell((ROWS - 2) * COLUMNS);
    read_cell((ROWS - 1) * COLUMNS);
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    out_stall_pct = 0;
    run_random_traffic(8'h00, 110, 1'b0);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 54;
    out_stall_pct = 0;
    run_random_traffic(8'hFF, 110, 1'b1);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    out_stall_pct = 54;
    run_random_traffic(8'($urandom), 110, 1'b0);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 20;
    out_stall_pct = 20;
    run_random_traffic(8'($urandom), 110, 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: cursor_position %0d read_data %0h scrolled %0b",
                 $time, out_cursor_position, out_read_data, out_scrolled);
        error_count++;
      end else begin
        popped_result = pending_results.pop_front();
        if (out_cursor_position !== popped_result.cursor_position) begin
          $display("%0t: cursor_position mismatch: expected %0d, actual %0d", $time,
                   popped_result.cursor_position, out_cursor_position);
          error_count++;
        end
        if (out_read_data !== popped_result.read_data) begin
          $display("%0t: read_data mismatch: expected %0h, actual %0h", $time,
                   popped_result.read_data, out_read_data);
          error_count++;
        end
        if (out_scrolled !== popped_result.scrolled) begin
          $display("%0t: scrolled mismatch: expected %0b, actual %0b", $time,
                   popped_result.scrolled, out_scrolled);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
        $display("text_console_writer regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = tcw_pkg::CMD_PUT;
    in_char_code     = 8'h00;
    in_cell_index    = 11'h000;
    out_stall        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = ADDR_ATTR;
    pwdata           = 32'h0;
    error_count      = 0;
    stuck_cycles     = 0;
    send_idle_pct    = 0;
    out_stall_pct    = 0;
    cursor_col_model = 0;
    cursor_row_model = 0;
    attr_model       = tcw_pkg::ATTR_RESET;
    for (int i = 0; i < CELLS; i++) begin
      screen_model[i] = '0;
      cell_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_put_and_controls();
    test_scroll();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tcw_pkg.sv
src/tcw_cell_mem.sv
src/tcw_cursor.sv
src/text_console_writer.sv
tb/tb_text_console_writer.sv
